@@ rtl/matrix_multiply_assert.svh @@
// Assertion helpers shared by the matrix multiply modules.
// Each macro expects the enclosing module to have i_clk and i_rst_n.
`ifndef MATRIX_MULTIPLY_ASSERT_SVH
`define MATRIX_MULTIPLY_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mm_pkg.sv @@
`timescale 1ns / 1ps

package mm_pkg;

    localparam int MAX_DIM_DEF = 8;
    localparam int IDX_W       = 3;
    localparam int VAL_W       = 32;
    localparam int FRAC_W      = 16;
    localparam int OPC_W       = 2;
    localparam int DIM_REG_W   = 4;
    localparam int APB_AW      = 4;
    localparam int APB_DW      = 32;

    // Cycles between the last multiply-accumulate issue and the result register.
    localparam int DRAIN_LEN   = 3;

    localparam logic [VAL_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] SAT_NEG = 32'h8000_0000;

    typedef enum logic [OPC_W-1:0] {
        OP_LOAD_A  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_COMPUTE = 2'd2
    } t_opcode;

    localparam logic [1:0] REG_ROWS_OF_A  = 2'd0;
    localparam logic [1:0] REG_INNER_SIZE = 2'd1;
    localparam logic [1:0] REG_COLS_OF_B  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    // Clamped dimensions, each held as its last index (dimension minus one).
    typedef struct packed {
        logic [IDX_W-1:0] m_last;
        logic [IDX_W-1:0] l_last;
        logic [IDX_W-1:0] n_last;
    } t_dims;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic             load_a;
        logic             load_b;
        logic             mac_valid;
        logic             first;
        logic             last_k;
        logic             last_run;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
        logic [IDX_W-1:0] k;
    } t_dp_cmd;

    // Tag that travels down the multiply-accumulate pipeline.
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last_k;
        logic             last_run;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
    } t_mac_tag;

endpackage

@@ rtl/matrix_multiply.sv @@
`timescale 1ns / 1ps

// Dense matrix product C = A x B on signed Q16.16 elements.
// Items enter on start when busy is low. Opcode load A or load B writes one
// element into the A or B store at the given row and column; a load leaves
// busy low, so loads can arrive on every cycle. Loads outside the store and
// the unused opcode are dropped without a result.
// A compute item raises busy until its m*n*l multiply-accumulates drain,
// where m, l and n are the clamped register values. One multiply-accumulate
// issues per cycle, set by the single multiplier and each store's read port.
// Each element of C passes the read, product, accumulate and output registers
// and appears as a one-cycle pulse on o_valid carrying row, column, value,
// overflow flag and last marker; results of one run come in row-major order.
// The receiver cannot stall: each result must be taken in its pulse cycle.
// Synchronous reset returns the controller to idle, clears the result strobe
// and sets all three dimension registers to eight. The element stores are
// not cleared; an element must be loaded before a compute reads it.
// Configuration goes over an APB port with registers at byte offsets
// 0, 4 and 8 and should only be written while busy is low.
module matrix_multiply
    import mm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Command channel.
    input  logic                    start,
    output logic                    busy,
    input  logic [OPC_W-1:0]        i_opcode,
    input  logic [IDX_W-1:0]        i_row_index,
    input  logic [IDX_W-1:0]        i_col_index,
    input  logic signed [VAL_W-1:0] i_element_value,
    // Result channel.
    output logic                    o_valid,
    output logic [IDX_W-1:0]        o_out_row,
    output logic [IDX_W-1:0]        o_out_col,
    output logic signed [VAL_W-1:0] o_product_value,
    output logic                    o_overflowed,
    output logic                    o_last_of_run,
    // Configuration port.
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_AW-1:0]       paddr,
    input  logic [APB_DW-1:0]       pwdata,
    output logic [APB_DW-1:0]       prdata,
    output logic                    pready
);

    t_dims   dims;
    t_dp_cmd dp_cmd;

    // Dimension registers, clamped to the range the store supports.
    mm_regs #(
        .MAX_DIM (MAX_DIM)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_dims  (dims)
    );

    // Sequencer: decodes items and walks the i, j, k loops of a compute.
    mm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_dims   (dims),
        .o_busy   (busy),
        .o_cmd    (dp_cmd)
    );

    // Element stores, multiplier, accumulator and the round and saturate stage.
    mm_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .i_row_index     (i_row_index),
        .i_col_index     (i_col_index),
        .i_element_value (i_element_value),
        .o_valid         (o_valid),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_product_value (o_product_value),
        .o_overflowed    (o_overflowed),
        .o_last_of_run   (o_last_of_run)
    );

endmodule

@@ rtl/mm_regs.sv @@
`timescale 1ns / 1ps

module mm_regs
    import mm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_dims             o_dims
);

    logic [DIM_REG_W-1:0] r_rows;
    logic [DIM_REG_W-1:0] r_inner;
    logic [DIM_REG_W-1:0] r_cols;
    logic                 wr_en;
    logic [1:0]           reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= DIM_REG_W'(MAX_DIM_DEF);
            r_inner <= DIM_REG_W'(MAX_DIM_DEF);
            r_cols  <= DIM_REG_W'(MAX_DIM_DEF);
        end else if (wr_en) begin
            case (reg_sel)
                REG_ROWS_OF_A:  r_rows  <= pwdata[DIM_REG_W-1:0];
                REG_INNER_SIZE: r_inner <= pwdata[DIM_REG_W-1:0];
                REG_COLS_OF_B:  r_cols  <= pwdata[DIM_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_ROWS_OF_A:  prdata = APB_DW'(r_rows);
            REG_INNER_SIZE: prdata = APB_DW'(r_inner);
            REG_COLS_OF_B:  prdata = APB_DW'(r_cols);
            default:        prdata = '0;
        endcase
    end

    // Zero counts as one and anything above the store size counts as the store size.
    function automatic logic [IDX_W-1:0] clamp_last(input logic [DIM_REG_W-1:0] v);
        logic [IDX_W-1:0] res;
        if (v == '0) begin
            res = '0;
        end else if (v > DIM_REG_W'(MAX_DIM)) begin
            res = IDX_W'(MAX_DIM - 1);
        end else begin
            res = IDX_W'(v - DIM_REG_W'(1));
        end
        return res;
    endfunction

    assign o_dims.m_last = clamp_last(r_rows);
    assign o_dims.l_last = clamp_last(r_inner);
    assign o_dims.n_last = clamp_last(r_cols);

endmodule

@@ rtl/mm_ctrl.sv @@
`timescale 1ns / 1ps
`include "matrix_multiply_assert.svh"

module mm_ctrl
    import mm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [OPC_W-1:0] i_opcode,
    input  t_dims            i_dims,
    output logic             o_busy,
    output t_dp_cmd          o_cmd
);

    localparam int DRAIN_W = $clog2(DRAIN_LEN);

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_i, n_i;
    logic [IDX_W-1:0]   r_j, n_j;
    logic [IDX_W-1:0]   r_k, n_k;
    logic [DRAIN_W-1:0] r_drain, n_drain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_drain <= '0;
        end else begin
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_drain <= n_drain;
        end
    end

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_drain = r_drain;
        o_busy  = (r_state != ST_IDLE);
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    case (i_opcode)
                        OP_LOAD_A:  o_cmd.load_a = 1'b1;
                        OP_LOAD_B:  o_cmd.load_b = 1'b1;
                        OP_COMPUTE: begin
                            n_state = ST_RUN;
                            n_i     = '0;
                            n_j     = '0;
                            n_k     = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN: begin
                o_cmd.mac_valid = 1'b1;
                o_cmd.first     = (r_k == '0);
                o_cmd.last_k    = (r_k == i_dims.l_last);
                o_cmd.last_run  = (r_k == i_dims.l_last) && (r_j == i_dims.n_last) &&
                                  (r_i == i_dims.m_last);
                o_cmd.i         = r_i;
                o_cmd.j         = r_j;
                o_cmd.k         = r_k;
                if (r_k != i_dims.l_last) begin
                    n_k = r_k + IDX_W'(1);
                end else begin
                    n_k = '0;
                    if (r_j != i_dims.n_last) begin
                        n_j = r_j + IDX_W'(1);
                    end else begin
                        n_j = '0;
                        if (r_i != i_dims.m_last) begin
                            n_i = r_i + IDX_W'(1);
                        end else begin
                            n_state = ST_DRAIN;
                            n_drain = DRAIN_W'(DRAIN_LEN - 1);
                        end
                    end
                end
            end
            ST_DRAIN: begin
                if (r_drain == '0) begin
                    n_state = ST_IDLE;
                end else begin
                    n_drain = r_drain - DRAIN_W'(1);
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    `MM_ASSERT_NEXT(a_compute_goes_busy, i_start && !o_busy && (i_opcode == OP_COMPUTE), o_busy, "compute item did not raise busy")
    `MM_ASSERT_SAME(a_index_in_range, o_cmd.mac_valid, (r_k <= i_dims.l_last) && (r_j <= i_dims.n_last) && (r_i <= i_dims.m_last), "loop index beyond dimension")
    `MM_ASSERT_SAME(a_load_only_idle, o_cmd.load_a || o_cmd.load_b, i_start && !o_busy && !o_cmd.mac_valid, "load issued while busy")

endmodule

@@ rtl/mm_dp.sv @@
`timescale 1ns / 1ps
`include "matrix_multiply_assert.svh"

module mm_dp
    import mm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    input  logic [IDX_W-1:0]        i_row_index,
    input  logic [IDX_W-1:0]        i_col_index,
    input  logic signed [VAL_W-1:0] i_element_value,
    output logic                    o_valid,
    output logic [IDX_W-1:0]        o_out_row,
    output logic [IDX_W-1:0]        o_out_col,
    output logic signed [VAL_W-1:0] o_product_value,
    output logic                    o_overflowed,
    output logic                    o_last_of_run
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PROD_W = 2 * VAL_W;
    localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;
    localparam int TOP_LO = FRAC_W + VAL_W - 1;

    logic [VAL_W-1:0]         r_mem_a [DEPTH];
    logic [VAL_W-1:0]         r_mem_b [DEPTH];
    logic signed [VAL_W-1:0]  r_rd_a;
    logic signed [VAL_W-1:0]  r_rd_b;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    t_mac_tag                 r_s1, r_s2, r_s3;
    t_mac_tag                 s0_tag;

    logic [ADDR_W-1:0]        wr_addr;
    logic [ADDR_W-1:0]        a_addr;
    logic [ADDR_W-1:0]        b_addr;
    logic                     wr_in_range;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  rounded;
    logic                     fits;

    assign wr_in_range = ({1'b0, i_row_index} < (IDX_W + 1)'(MAX_DIM)) &&
                         ({1'b0, i_col_index} < (IDX_W + 1)'(MAX_DIM));
    assign wr_addr = ADDR_W'(i_row_index) * ADDR_W'(MAX_DIM) + ADDR_W'(i_col_index);
    assign a_addr  = ADDR_W'(i_cmd.i) * ADDR_W'(MAX_DIM) + ADDR_W'(i_cmd.k);
    assign b_addr  = ADDR_W'(i_cmd.k) * ADDR_W'(MAX_DIM) + ADDR_W'(i_cmd.j);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_a && wr_in_range) begin
            r_mem_a[wr_addr] <= i_element_value;
        end
        r_rd_a <= r_mem_a[a_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_b && wr_in_range) begin
            r_mem_b[wr_addr] <= i_element_value;
        end
        r_rd_b <= r_mem_b[b_addr];
    end

    assign s0_tag.valid    = i_cmd.mac_valid;
    assign s0_tag.first    = i_cmd.first;
    assign s0_tag.last_k   = i_cmd.last_k;
    assign s0_tag.last_run = i_cmd.last_run;
    assign s0_tag.i        = i_cmd.i;
    assign s0_tag.j        = i_cmd.j;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
            r_s3.valid <= 1'b0;
        end else begin
            r_s1.valid <= s0_tag.valid;
            r_s2.valid <= r_s1.valid;
            r_s3.valid <= r_s2.valid;
        end
        r_s1.first    <= s0_tag.first;
        r_s1.last_k   <= s0_tag.last_k;
        r_s1.last_run <= s0_tag.last_run;
        r_s1.i        <= s0_tag.i;
        r_s1.j        <= s0_tag.j;
        r_s2.first    <= r_s1.first;
        r_s2.last_k   <= r_s1.last_k;
        r_s2.last_run <= r_s1.last_run;
        r_s2.i        <= r_s1.i;
        r_s2.j        <= r_s1.j;
        r_s3.first    <= r_s2.first;
        r_s3.last_k   <= r_s2.last_k;
        r_s3.last_run <= r_s2.last_run;
        r_s3.i        <= r_s2.i;
        r_s3.j        <= r_s2.j;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_rd_a * r_rd_b;
    end

    assign prod_ext = {{(ACC_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};

    // The sum is exact; no product sum of this length can overflow ACC_W bits.
    always_ff @(posedge i_clk) begin
        if (r_s2.valid) begin
            r_acc <= r_s2.first ? prod_ext : r_acc + prod_ext;
        end
    end

    // Add one half and take the floor, then check that everything above the
    // result's sign bit is a copy of it.
    assign rounded = r_acc + ACC_W'(1 << (FRAC_W - 1));
    assign fits    = (&rounded[ACC_W-1:TOP_LO]) || !(|rounded[ACC_W-1:TOP_LO]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_s3.valid && r_s3.last_k;
        end
        o_out_row     <= r_s3.i;
        o_out_col     <= r_s3.j;
        o_last_of_run <= r_s3.valid && r_s3.last_run;
        o_overflowed  <= !fits;
        if (fits) begin
            o_product_value <= rounded[TOP_LO:FRAC_W];
        end else if (rounded[ACC_W-1]) begin
            o_product_value <= SAT_NEG;
        end else begin
            o_product_value <= SAT_POS;
        end
    end

    `MM_ASSERT_SAME(a_last_has_valid, o_last_of_run, o_valid, "last marker without a result")
    `MM_ASSERT_SAME(a_sat_value, o_valid && o_overflowed, (o_product_value == SAT_POS) || (o_product_value == SAT_NEG), "overflow flag with unsaturated value")

endmodule
